// File: hw/rtl/dfb2_pkg.sv
// ----------------------------------------------------------------------------
// dfb2_pkg: shared types and constants of the decimate-by-two FIR filter
// Widths, limits, sequencer states and the sequencer-to-datapath bundle.
// ----------------------------------------------------------------------------
package dfb2_pkg;

  localparam int unsigned MaxTaps   = 8;
  localparam int unsigned MaxLine   = 1024;
  localparam int unsigned ResultCap = 5;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned TapCntW = 4;
  localparam int unsigned TapIdxW = $clog2(MaxTaps);
  localparam int unsigned PosW    = 11;
  localparam int unsigned OutIdxW = 10;
  localparam int unsigned ProdW   = SampleW + CoefW;
  localparam int unsigned AccW    = ProdW + 3;
  localparam int unsigned FracW   = 14;
  localparam int unsigned ResW    = 20;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTapCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTapsLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTapsHigh = 2'd2;

  localparam logic [TapCntW-1:0] TapCountReset = TapCntW'(MaxTaps);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } dfb2_state_e;

  typedef struct packed {
    logic               busy;
    logic               mac_clr;
    logic               mac_en;
    logic               tap_ok;
    logic [TapIdxW-1:0] tap_idx;
    logic [TapIdxW-1:0] win_idx;
    logic               emit;
    logic               mark;
    logic               win_clr;
  } dfb2_ctrl_t;

endpackage

// File: hw/rtl/dfb2_mac.sv
// ----------------------------------------------------------------------------
// dfb2_mac: shared multiply-accumulate unit
// One 16x16 product per cycle, registered, then summed; round and saturate.
// ----------------------------------------------------------------------------
module dfb2_mac
  import dfb2_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic                      en_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic signed [CoefW-1:0]   coef_i,
  output logic signed [ResW-1:0]    result_o
);

  localparam int unsigned ShW = AccW - FracW;
  localparam logic signed [ShW-1:0] SatMax = ShW'((1 << (ResW - 1)) - 1);
  localparam logic signed [ShW-1:0] SatMin = -ShW'(1 << (ResW - 1));
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1 << (FracW - 1));

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  rounded;
  logic signed [ShW-1:0]   shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * coef_i;
    acc_q  <= acc_d;
  end

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  // round half up, then floor shift
  assign rounded = acc_q + RoundHalf;
  assign shifted = rounded[AccW-1:FracW];

  always_comb begin
    if (shifted > SatMax) begin
      result_o = SatMax[ResW-1:0];
    end else if (shifted < SatMin) begin
      result_o = SatMin[ResW-1:0];
    end else begin
      result_o = shifted[ResW-1:0];
    end
  end

endmodule

// File: hw/rtl/dfb2_seq.sv
// ----------------------------------------------------------------------------
// dfb2_seq: line tracking and tap sequencer
// Decides which outputs a beat produces and walks the taps of each one.
// ----------------------------------------------------------------------------
module dfb2_seq
  import dfb2_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               line_end_i,
  input  logic [TapCntW-1:0] taps_i,
  input  logic               out_free_i,
  output dfb2_ctrl_t         ctrl_o
);

  dfb2_state_e state_q, state_d;

  logic [PosW-1:0]    lp_q, p_q;
  logic               last_q, phase_q;
  logic [OutIdxW-1:0] noi_q, nout_q, fstart_q, c_q;
  logic [TapIdxW-1:0] j_q;

  // setup arithmetic
  logic [TapCntW-1:0] span;
  logic [PosW:0]      need_pos;
  logic               reg_hit;
  logic [OutIdxW-1:0] noi_after, nout, gap, fstart;
  logic [PosW:0]      len;
  logic [2:0]         room;
  logic               flush_any;
  logic               more;
  logic               last_tap;
  logic               line_full;

  // tap addressing
  logic [PosW-1:0] q_pos, win_dist;

  assign line_full = ({1'b0, lp_q} + (PosW+1)'(1)) >= (PosW+1)'(MaxLine);

  always_comb begin
    span      = (taps_i < TapCntW'(2)) ? TapCntW'(2) : taps_i;
    need_pos  = {1'b0, noi_q, 1'b0} + (PosW+1)'(span) - (PosW+1)'(1);
    reg_hit   = need_pos <= {1'b0, p_q};
    noi_after = noi_q + OutIdxW'(reg_hit);
    len       = {1'b0, p_q} + (PosW+1)'(1);
    nout      = len[OutIdxW:1];
    room      = 3'(ResultCap) - 3'(reg_hit);
    gap       = nout - noi_after;
    fstart    = ((noi_after < nout) && (gap > OutIdxW'(room))) ?
                nout - OutIdxW'(room) : noi_after;
    flush_any = last_q && (fstart < nout);
  end

  assign more = phase_q ? ((c_q + OutIdxW'(1)) < nout_q) :
                          (last_q && (fstart_q < nout_q));
  assign last_tap = ({1'b0, j_q} == (taps_i - TapCntW'(1)));

  assign q_pos    = {c_q, 1'b0} + PosW'(j_q);
  assign win_dist = p_q - q_pos;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = (reg_hit || flush_any) ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        if (last_tap) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) state_d = more ? ST_MAC : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.busy    = (state_q != ST_IDLE);
    ctrl_o.tap_idx = j_q;
    ctrl_o.win_idx = win_dist[TapIdxW-1:0];
    ctrl_o.tap_ok  = (q_pos <= p_q) && (win_dist < PosW'(MaxTaps));
    ctrl_o.mark    = last_q && (({1'b0, c_q} + (OutIdxW+1)'(1)) == {1'b0, nout_q});
    unique case (state_q)
      ST_SETUP: begin
        ctrl_o.mac_clr = 1'b1;
        ctrl_o.win_clr = last_q && !(reg_hit || flush_any);
      end
      ST_MAC: begin
        ctrl_o.mac_en = 1'b1;
      end
      ST_EMIT: begin
        ctrl_o.emit    = out_free_i;
        ctrl_o.mac_clr = out_free_i;
        ctrl_o.win_clr = out_free_i && !more && last_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      lp_q     <= '0;
      p_q      <= '0;
      last_q   <= 1'b0;
      noi_q    <= '0;
      nout_q   <= '0;
      fstart_q <= '0;
      c_q      <= '0;
      phase_q  <= 1'b0;
      j_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && accept_i) begin
        p_q    <= lp_q;
        last_q <= line_end_i || line_full;
        lp_q   <= (line_end_i || line_full) ? '0 : lp_q + PosW'(1);
      end
      if (state_q == ST_SETUP) begin
        nout_q   <= nout;
        fstart_q <= fstart;
        noi_q    <= last_q ? '0 : noi_after;
        c_q      <= reg_hit ? noi_q : fstart;
        phase_q  <= !reg_hit;
        j_q      <= '0;
      end
      if (state_q == ST_MAC) begin
        j_q <= j_q + TapIdxW'(1);
      end
      if (state_q == ST_EMIT && out_free_i && more) begin
        j_q <= '0;
        if (phase_q) begin
          c_q <= c_q + OutIdxW'(1);
        end else begin
          c_q     <= fstart_q;
          phase_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/decimating_fir_by_two.sv
// ----------------------------------------------------------------------------
// decimating_fir_by_two: decimate-by-two FIR analysis filter for one line
// Samples in, every second position filtered out; one shared MAC unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample beat with
//   line_end_i on the final sample of a line. Output channel (out_valid_o /
//   out_stall_i) carries filtered_o with last_of_line_o on the line's final
//   output. Configure tap_count and the two packed coefficient groups through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle.
// Sequencing:
//   Each accepted sample beat passes a setup step, after which a beat that
//   yields no output returns to idle. Each output walks the T taps in use
//   in the MAC step, then passes a drain step for the product register and
//   an emit step. An ordinary beat yields at most one output, a line-end
//   beat up to five; the input stays stalled until the beat is done. Each
//   output appears in the cycle after its emit step, registered.
// Reset clears the window, line position and output index, sets tap_count
// to 8 and the coefficients to zero. A stall on the output holds the result
// register and parks the sequencer in its emit step; the input stays stalled.
// ----------------------------------------------------------------------------
module decimating_fir_by_two
  import dfb2_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_wdata_i,
  // sample input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      line_end_i,
  // filtered output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ResW-1:0]    filtered_o,
  output logic                      last_of_line_o
);

  logic [TapCntW-1:0] tap_count_q;
  logic [CfgW-1:0]    taps_lo_q, taps_hi_q;
  logic [TapCntW-1:0] taps_used;

  logic signed [SampleW-1:0] win_q [MaxTaps];

  dfb2_ctrl_t ctrl;
  logic       accept;
  logic       out_free;

  logic [2*CfgW-1:0]         coef_bank;
  logic signed [CoefW-1:0]   coef;
  logic signed [SampleW-1:0] mac_sample;
  logic signed [ResW-1:0]    mac_result;

  logic                   out_vld_q;
  logic signed [ResW-1:0] filtered_q;
  logic                   mark_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TapCountReset;
      taps_lo_q   <= '0;
      taps_hi_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTapCount: tap_count_q <= cfg_wdata_i[TapCntW-1:0];
        CfgTapsLow:  taps_lo_q   <= cfg_wdata_i;
        CfgTapsHigh: taps_hi_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp tap count: zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (tap_count_q == '0) begin
      taps_used = TapCntW'(1);
    end else if (tap_count_q > TapCntW'(MaxTaps)) begin
      taps_used = TapCntW'(MaxTaps);
    end else begin
      taps_used = tap_count_q;
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = ctrl.busy;
  assign out_free   = !out_vld_q || !out_stall_i;

  dfb2_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .line_end_i (line_end_i),
    .taps_i     (taps_used),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // sample window, newest first; advance on each beat, drop at line end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxTaps; k++) win_q[k] <= '0;
    end else if (accept) begin
      win_q[0] <= sample_i;
      for (int k = 1; k < MaxTaps; k++) win_q[k] <= win_q[k-1];
    end else if (ctrl.win_clr) begin
      for (int k = 0; k < MaxTaps; k++) win_q[k] <= '0;
    end
  end

  // operand select: samples outside the line or the window read as zero
  assign coef_bank  = {taps_hi_q, taps_lo_q};
  assign coef       = coef_bank[{ctrl.tap_idx, 4'b0000} +: CoefW];
  assign mac_sample = ctrl.tap_ok ? win_q[ctrl.win_idx] : '0;

  dfb2_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (ctrl.mac_clr),
    .en_i     (ctrl.mac_en),
    .sample_i (mac_sample),
    .coef_i   (coef),
    .result_o (mac_result)
  );

  // output register: load on emit, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      filtered_q <= mac_result;
      mark_q     <= ctrl.mark;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign filtered_o     = filtered_q;
  assign last_of_line_o = mark_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the decimate-by-two FIR filter
// Feeds lines of samples through the valid/stall input with random gaps,
// stalls the output at random, and checks every output beat against a
// bit-exact software copy of the filter held in this module.
// ----------------------------------------------------------------------------
module testbench;
  import dfb2_pkg::*;

  localparam int          HalfPeriod   = 2;
  localparam int unsigned WinDepth     = 8;
  // longest beat: five outputs of a full eight-tap line end, plus margin
  localparam int unsigned SettleCycles = ResultCap * (MaxTaps + 2) + 16;
  localparam longint      OutMax       = (longint'(1) <<< (ResW - 1)) - 1;
  localparam longint      OutMin       = -(longint'(1) <<< (ResW - 1));
  localparam int unsigned RandomBeats  = 500;

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      line_end;
  } sample_beat_t;

  typedef struct packed {
    logic signed [ResW-1:0] filtered;
    logic                   last;
  } fir_out_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i   = CfgTapCount;
  logic [CfgW-1:0]           cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_i    = '0;
  logic                      line_end_i  = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [ResW-1:0]    filtered_o;
  logic                      last_of_line_o;

  decimating_fir_by_two u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .line_end_i     (line_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_o     (filtered_o),
    .last_of_line_o (last_of_line_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Filter copy: registers and line state as the block should hold them
  // --------------------------------------------------------------------------
  logic [TapCntW-1:0]        tap_cnt_reg = TapCountReset;
  logic [CfgW-1:0]           coef_lo_reg = '0;
  logic [CfgW-1:0]           coef_hi_reg = '0;
  logic signed [SampleW-1:0] line_window [WinDepth];
  int unsigned               line_pos    = 0;
  int unsigned               out_pos     = 0;

  sample_beat_t sample_beats [$];   // beats waiting for the driver
  fir_out_t     due_outputs  [$];   // outputs the block still owes
  int unsigned  err_count = 0;

  initial begin
    foreach (line_window[k]) line_window[k] = '0;
  end

  // tap_count 0 behaves as one tap, anything above MaxTaps as MaxTaps
  function automatic int unsigned taps_active();
    int unsigned t;
    t = tap_cnt_reg;
    if (t < 1) t = 1;
    if (t > MaxTaps) t = MaxTaps;
    return t;
  endfunction

  function automatic logic signed [CoefW-1:0] tap_coef(int unsigned j);
    logic [CfgW-1:0] grp;
    grp = (j < 4) ? coef_lo_reg : coef_hi_reg;
    return grp[CoefW*(j%4) +: CoefW];
  endfunction

  // One output point: taps past the line end or out of the window read zero,
  // then round half up, floor-shift by FracW and clamp to ResW bits.
  function automatic logic signed [ResW-1:0] fir_point(int unsigned c, int unsigned p,
                                                       int unsigned len, int unsigned t);
    longint      acc;
    int unsigned q;
    acc = 0;
    for (int unsigned j = 0; j < t; j++) begin
      q = 2*c + j;
      if (q < len && q <= p && p - q < WinDepth)
        acc += longint'(line_window[p-q]) * longint'(tap_coef(j));
    end
    acc = (acc + (longint'(1) <<< (FracW - 1))) >>> FracW;
    if (acc > OutMax) acc = OutMax;
    if (acc < OutMin) acc = OutMin;
    return acc[ResW-1:0];
  endfunction

  // Advance the filter copy by one accepted beat and queue what it owes.
  task automatic advance_filter(input logic signed [SampleW-1:0] s, input logic le);
    int unsigned p, t, span, len, nout, c, room, n;
    bit          closes;
    fir_out_t    res;
    p      = line_pos;
    t      = taps_active();
    span   = (t < 2) ? 2 : t;
    closes = le || (p + 1 >= MaxLine);
    len    = p + 1;
    nout   = len / 2;
    n      = 0;
    for (int k = WinDepth - 1; k > 0; k--) line_window[k] = line_window[k-1];
    line_window[0] = s;
    // at most one output per ordinary beat, once its last sample is in
    if (2*out_pos + span - 1 <= p) begin
      res.filtered = fir_point(out_pos, p, len, t);
      res.last     = closes && (out_pos + 1 == nout);
      due_outputs.push_back(res);
      n++;
      out_pos++;
    end
    if (closes) begin
      // flush the pending tail; only the newest ResultCap outputs survive
      c    = out_pos;
      room = ResultCap - n;
      if (c < nout && nout - c > room) c = nout - room;
      for (; c < nout; c++) begin
        res.filtered = fir_point(c, p, len, t);
        res.last     = (c + 1 == nout);
        due_outputs.push_back(res);
      end
      line_pos = 0;
      out_pos  = 0;
      foreach (line_window[k]) line_window[k] = '0;
    end else begin
      line_pos = (p + 1) % (1 << PosW);
      out_pos  = out_pos % (1 << OutIdxW);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Idling: mostly short gaps, a few long ones, and calm stretches with none
  // --------------------------------------------------------------------------
  logic        in_calm  = 1'b0;
  logic        out_calm = 1'b0;
  int unsigned in_gap   = 0;
  int unsigned out_hold = 0;

  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) in_calm <= !in_calm;
    if ($urandom_range(0, 299) == 0) out_calm <= !out_calm;
  end

  // --------------------------------------------------------------------------
  // Driver: hold a stalled beat, otherwise wait out the gap and load the next
  // --------------------------------------------------------------------------
  sample_beat_t next_beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
      line_end_i <= 1'b0;
      in_gap     <= 0;
    end else begin
      // predict on the beat the block takes at this edge
      if (in_valid_i && !in_stall_o) advance_filter(sample_i, line_end_i);
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (sample_beats.size() != 0) begin
          next_beat   = sample_beats.pop_front();
          sample_i   <= next_beat.sample;
          line_end_i <= next_beat.line_end;
          in_valid_i <= 1'b1;
          in_gap     <= pick_gap(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each taken output beat, then pick the next stall level
  // --------------------------------------------------------------------------
  fir_out_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_outputs.size() == 0) begin
          report_mismatch($sformatf("output beat %0d/%0b with nothing due",
                                    filtered_o, last_of_line_o));
        end else begin
          want = due_outputs.pop_front();
          if (filtered_o !== want.filtered)
            report_mismatch($sformatf("filtered got %0d, expected %0d",
                                      filtered_o, want.filtered));
          if (last_of_line_o !== want.last)
            report_mismatch($sformatf("last_of_line got %b, expected %b",
                                      last_of_line_o, want.last));
        end
      end
      if (out_hold != 0) begin
        out_stall_i <= 1'b1;
        out_hold    <= out_hold - 1;
      end else if (!out_calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        out_hold    <= pick_gap(1'b0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic signed [SampleW-1:0] s, input logic le);
    sample_beat_t b;
    b.sample   = s;
    b.line_end = le;
    sample_beats.push_back(b);
  endtask

  // Write one register; the block must be idle. Update the filter copy too.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgTapCount: tap_cnt_reg = data[TapCntW-1:0];
      CfgTapsLow:  coef_lo_reg = data;
      CfgTapsHigh: coef_hi_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Drain: all beats taken, all outputs seen, then let a silent beat finish.
  task automatic drain_block();
    while (sample_beats.size() != 0 || in_valid_i || due_outputs.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7FFF;
    if (r == 2) return SampleW'(int'($urandom_range(0, 64)) - 32);
    return SampleW'($urandom());
  endfunction

  function automatic logic [CfgW-1:0] rand_coefs();
    logic [CfgW-1:0] v;
    int unsigned     r;
    for (int lane = 0; lane < 4; lane++) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       v[CoefW*lane +: CoefW] = 16'h8000;
        1:       v[CoefW*lane +: CoefW] = 16'h7FFF;
        2:       v[CoefW*lane +: CoefW] = 16'h4000;
        3:       v[CoefW*lane +: CoefW] = 16'hC000;
        4:       v[CoefW*lane +: CoefW] = CoefW'(int'($urandom_range(0, 255)) - 128);
        default: v[CoefW*lane +: CoefW] = CoefW'($urandom());
      endcase
    end
    return v;
  endfunction

  // mostly 1..8 taps, with 0 and the values above MaxTaps now and then
  function automatic logic [CfgW-1:0] rand_tap_count();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CfgW'($urandom_range(MaxTaps + 1, (1 << TapCntW) - 1));
    if (r == 2) return CfgW'(MaxTaps);
    if (r == 3) return CfgW'(1);
    return CfgW'($urandom_range(1, MaxTaps));
  endfunction

  task automatic queue_line(input int unsigned len, input logic closed);
    for (int unsigned i = 0; i < len; i++)
      push_beat(rand_sample(), closed && (i + 1 == len));
  endtask

  // --------------------------------------------------------------------------
  // Run: directed lines, random lines, one over-long line, then the verdict
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent, len, cut, r;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: eight taps, all coefficients zero
    push_beat(16'sh0123, 1'b0);
    push_beat(16'sh8000, 1'b0);
    push_beat(16'sh7FFF, 1'b1);
    drain_block();

    // all coefficients at -2.0: the first output of a full line of -32768
    // clips high, that of a full line of 32767 lands near the negative end
    write_reg(CfgTapCount, CfgW'(MaxTaps));
    write_reg(CfgTapsLow,  {4{16'h8000}});
    write_reg(CfgTapsHigh, {4{16'h8000}});
    for (int i = 0; i < 8; i++) push_beat(16'sh8000, i == 7);
    for (int i = 0; i < 8; i++) push_beat(16'sh7FFF, i == 7);
    // a lone sample yields nothing; two samples yield one marked output
    push_beat(16'sh1234, 1'b1);
    push_beat(16'shFEDC, 1'b0);
    push_beat(16'sh0FF0, 1'b1);
    drain_block();

    // tap count zero runs as a single tap
    write_reg(CfgTapCount, '0);
    write_reg(CfgTapsLow, rand_coefs());
    queue_line(3, 1'b1);

    // random lines under shifting settings
    sent = 0;
    while (sent < RandomBeats) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_block();
        write_reg(CfgTapCount, rand_tap_count());
        if ($urandom_range(0, 1) == 0) write_reg(CfgTapsLow, rand_coefs());
        if ($urandom_range(0, 1) == 0) write_reg(CfgTapsHigh, rand_coefs());
      end
      r = $urandom_range(0, 99);
      if (r < 10)      len = $urandom_range(1, 3);
      else if (r < 80) len = $urandom_range(4, 24);
      else if (r < 97) len = $urandom_range(25, 80);
      else             len = $urandom_range(81, 200);
      if (len > 4 && $urandom_range(0, 7) == 0) begin
        // retune the tap count partway through the line
        cut = $urandom_range(2, len - 2);
        queue_line(cut, 1'b0);
        drain_block();
        write_reg(CfgTapCount, rand_tap_count());
        queue_line(len - cut, 1'b1);
      end else begin
        queue_line(len, 1'b1);
      end
      sent += len;
    end

    // a line without an end mark closes itself at MaxLine; a short one follows
    drain_block();
    write_reg(CfgTapCount, rand_tap_count());
    queue_line(MaxLine + 6, 1'b1);

    drain_block();
    if (err_count == 0) begin
      $display("** decimating_fir_by_two: PASSED **");
    end else begin
      $display("** decimating_fir_by_two: FAILED **");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #3000000;
    $display("** decimating_fir_by_two: FAILED **");
    $finish;
  end

endmodule

// File: decimating_fir_by_two.f
hw/rtl/dfb2_pkg.sv
hw/rtl/dfb2_mac.sv
hw/rtl/dfb2_seq.sv
hw/rtl/decimating_fir_by_two.sv
bench/testbench.sv
